// ===== rtl/pi_throttle_controller_assert.svh =====
// assertion macros for the pi throttle controller
// used by modules that check their own control logic; expects clk and rst_n in scope
`ifndef PI_THROTTLE_CONTROLLER_ASSERT_SVH
`define PI_THROTTLE_CONTROLLER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PITC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PITC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pitc_pkg.sv =====
// types and constants for the pi throttle controller
// no dependencies
package pitc_pkg;

  localparam int ENERGY_W   = 32;
  localparam int DT_W       = 17;
  localparam int GAIN_W     = 24;
  localparam int THR_W      = 17;
  localparam int LIM_W      = 31;
  localparam int FRAC_W     = 16;
  localparam int ERR_W      = 33;
  localparam int ACC_W      = 58;
  localparam int CNT_W      = 5;
  localparam int DT_PROD_W  = 34;
  localparam int SUM_W      = 35;
  localparam int CORR_W     = ACC_W - FRAC_W;
  localparam int OUTV_W     = CORR_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DT_W-1:0] DT_ONE = 17'h10000;

  typedef enum logic [1:0] {
    OP_SET_TARGET   = 2'd0,
    OP_SET_MEASURED = 2'd1,
    OP_TICK         = 2'd2
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_CEILING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEADY_LEVEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT   = 3'd5;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST        = 24'd32768;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST       = 24'd6554;
  localparam logic [THR_W-1:0]  THROTTLE_CEILING_RST = 17'd65536;
  localparam logic [THR_W-1:0]  THROTTLE_FLOOR_RST   = 17'd0;
  localparam logic [THR_W-1:0]  STEADY_LEVEL_RST     = 17'd26214;
  localparam logic [LIM_W-1:0]  INTEGRAL_LIMIT_RST   = 31'd32768;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_DT,
    S_INTEG,
    S_MUL_P,
    S_MUL_I,
    S_OUT
  } pitc_state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

endpackage

// ===== rtl/pitc_serial_mac.sv =====
// bit-serial shift-add multiply-accumulate unit, one multiplier bit per cycle
// depends on pitc_pkg
module pitc_serial_mac import pitc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctrl_t                ctrl,
  input  logic signed [ERR_W-1:0]  mcand,
  input  logic [GAIN_W-1:0]        mult,
  output mac_stat_t                stat,
  output logic signed [ACC_W-1:0]  acc
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] mcand_r, mcand_nxt;
  logic [GAIN_W-1:0]       mult_r, mult_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;

  always_comb begin
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    mult_nxt  = mult_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (ctrl.start) begin
      mcand_nxt = ACC_W'(mcand);
      mult_nxt  = mult;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
      if (ctrl.clear) begin
        acc_nxt = '0;
      end
    end else if (busy_r) begin
      if (mult_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r <<< 1;
      mult_nxt  = mult_r >> 1;
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mult_r  <= mult_nxt;
  end

  assign acc       = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/pi_throttle_controller.sv =====
// Fixed-point PI throttle regulator with anti-windup clamp. Items that set the target or
// measured energy are taken in S_IDLE. A valid control tick holds the input channel through
// S_MUL_DT, S_INTEG, S_MUL_P, S_MUL_I and S_OUT: the three products (error times dt, prop
// gain times error, integral gain times integral) run one after another through a single
// bit-serial shift-add unit of 24 steps each, with the integral clamp in S_INTEG and the output
// clamp in S_OUT. The result sits in an output register, so the next item is taken while it
// waits. Config writes are always ready and take effect at once.
// depends on pitc_pkg, pitc_serial_mac and pi_throttle_controller_assert.svh
`include "pi_throttle_controller_assert.svh"

module pi_throttle_controller import pitc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_opcode,
  input  logic signed [ENERGY_W-1:0] in_energy_value,
  input  logic [DT_W-1:0]        in_elapsed_time,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [THR_W-1:0]       out_throttle,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  pitc_state_t state_r, state_nxt;

  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r;
  logic [THR_W-1:0]  ceiling_r, floor_r, steady_r;
  logic [LIM_W-1:0]  lim_r;

  logic signed [ENERGY_W-1:0] target_r, measured_r, integ_r;
  logic                       t_seen_r, m_seen_r;
  logic signed [ERR_W-1:0]    err_r;
  logic                       out_valid_r;
  logic [THR_W-1:0]           out_throttle_r;

  logic accept, tick_ok, load_out, integ_load;
  mac_ctrl_t mac_ctrl;
  mac_stat_t mac_st;
  logic signed [ERR_W-1:0] mac_mcand, err_calc;
  logic [GAIN_W-1:0]       mac_mult;
  logic signed [ACC_W-1:0] acc;

  logic signed [DT_PROD_W-1:0] dt_prod;
  logic signed [SUM_W-1:0]     sum, lim_s, integ_clamp;
  logic signed [ENERGY_W-1:0]  integ_nxt;
  logic signed [CORR_W-1:0]    corr;
  logic signed [OUTV_W-1:0]    outv, hi_s, lo_s, outv_clamp;
  logic signed [SUM_W-1:0]     integ_ext;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign tick_ok   = (in_opcode == OP_TICK) && t_seen_r && m_seen_r &&
                     (in_elapsed_time != '0) && (in_elapsed_time <= DT_ONE);
  assign err_calc  = ERR_W'(target_r) - ERR_W'(measured_r);

  // integral update
  assign dt_prod     = acc[FRAC_W+DT_PROD_W-1:FRAC_W];
  assign sum         = SUM_W'(integ_r) + SUM_W'(dt_prod);
  assign lim_s       = $signed(SUM_W'(lim_r));
  always_comb begin
    priority if (sum > lim_s) begin
      integ_clamp = lim_s;
    end else if (sum < -lim_s) begin
      integ_clamp = -lim_s;
    end else begin
      integ_clamp = sum;
    end
  end
  assign integ_nxt = ENERGY_W'(integ_clamp);

  // output clamp, floor applied last
  assign corr = acc[ACC_W-1:FRAC_W];
  assign outv = $signed(OUTV_W'(steady_r)) + OUTV_W'(corr);
  assign hi_s = $signed(OUTV_W'(ceiling_r));
  assign lo_s = $signed(OUTV_W'(floor_r));
  always_comb begin
    outv_clamp = outv;
    if (outv_clamp > hi_s) begin
      outv_clamp = hi_s;
    end
    if (outv_clamp < lo_s) begin
      outv_clamp = lo_s;
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE: begin
        mac_mcand = err_calc;
        mac_mult  = GAIN_W'(in_elapsed_time);
      end
      S_INTEG: begin
        mac_mcand = err_r;
        mac_mult  = prop_gain_r;
      end
      default: begin
        mac_mcand = ERR_W'(integ_r);
        mac_mult  = integ_gain_r;
      end
    endcase
  end

  pitc_serial_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .mcand (mac_mcand),
    .mult  (mac_mult),
    .stat  (mac_st),
    .acc   (acc)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept && tick_ok) state_nxt = S_MUL_DT;
      S_MUL_DT: if (mac_st.done) state_nxt = S_INTEG;
      S_INTEG:  state_nxt = S_MUL_P;
      S_MUL_P:  if (mac_st.done) state_nxt = S_MUL_I;
      S_MUL_I:  if (mac_st.done) state_nxt = S_OUT;
      S_OUT:    if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall       = 1'b1;
    mac_ctrl.start = 1'b0;
    mac_ctrl.clear = 1'b0;
    load_out       = 1'b0;
    integ_load     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall       = 1'b0;
        mac_ctrl.start = in_valid && tick_ok;
        mac_ctrl.clear = 1'b1;
      end
      S_INTEG: begin
        integ_load     = 1'b1;
        mac_ctrl.start = 1'b1;
        mac_ctrl.clear = 1'b1;
      end
      S_MUL_P: begin
        mac_ctrl.start = mac_st.done;
      end
      S_OUT: begin
        load_out = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      ceiling_r    <= THROTTLE_CEILING_RST;
      floor_r      <= THROTTLE_FLOOR_RST;
      steady_r     <= STEADY_LEVEL_RST;
      lim_r        <= INTEGRAL_LIMIT_RST;
      target_r     <= '0;
      measured_r   <= '0;
      integ_r      <= '0;
      t_seen_r     <= 1'b0;
      m_seen_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PROP_GAIN:        prop_gain_r  <= cfg_data[GAIN_W-1:0];
          REG_INTEG_GAIN:       integ_gain_r <= cfg_data[GAIN_W-1:0];
          REG_THROTTLE_CEILING: ceiling_r    <= cfg_data[THR_W-1:0];
          REG_THROTTLE_FLOOR:   floor_r      <= cfg_data[THR_W-1:0];
          REG_STEADY_LEVEL:     steady_r     <= cfg_data[THR_W-1:0];
          REG_INTEGRAL_LIMIT:   lim_r        <= cfg_data[LIM_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept && (in_opcode == OP_SET_TARGET)) begin
        target_r <= in_energy_value;
        t_seen_r <= 1'b1;
      end
      if (accept && (in_opcode == OP_SET_MEASURED)) begin
        measured_r <= in_energy_value;
        m_seen_r   <= 1'b1;
      end
      if (integ_load) begin
        integ_r <= integ_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      err_r <= err_calc;
    end
    if (load_out) begin
      out_throttle_r <= outv_clamp[THR_W-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_throttle = out_throttle_r;

  // integral stays inside the anti-windup bound once updated
  assign integ_ext = SUM_W'(integ_r);

  `PITC_ASSERT_NXT(a_integ_bound, state_r == S_INTEG,
    (integ_ext <= lim_s) && (integ_ext >= -lim_s), "integral outside limit")
  `PITC_ASSERT_IMP(a_mac_busy_state, mac_st.busy,
    state_r == S_MUL_DT || state_r == S_MUL_P || state_r == S_MUL_I, "mac busy out of sequence")
  `PITC_ASSERT_NXT(a_out_only_from_out, (state_r != S_OUT) && !out_valid_r,
    !out_valid_r, "result without a finished tick")

endmodule

// ===== test/pi_throttle_controller_test.sv =====
// self-checking testbench for pi_throttle_controller: random and directed energy and tick items,
// throttle results checked against an in-bench fixed-point pi predictor
// depends on pitc_pkg and the pi_throttle_controller rtl
`timescale 1ns / 1ps

module pi_throttle_controller_test;
  import pitc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int IDLE_PCT = 34;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [1:0] opcode;
    logic signed [ENERGY_W-1:0] energy;
    logic [DT_W-1:0] dt;
  } ctrl_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = OP_SET_TARGET;
  logic signed [ENERGY_W-1:0] in_energy_value = '0;
  logic [DT_W-1:0] in_elapsed_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [THR_W-1:0] out_throttle;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pi_throttle_controller uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_energy_value(in_energy_value),
    .in_elapsed_time(in_elapsed_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_throttle(out_throttle),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of registers and regulator state
  logic [GAIN_W-1:0] gain_p = PROP_GAIN_RST;
  logic [GAIN_W-1:0] gain_i = INTEG_GAIN_RST;
  logic [THR_W-1:0] ceiling_lvl = THROTTLE_CEILING_RST;
  logic [THR_W-1:0] floor_lvl = THROTTLE_FLOOR_RST;
  logic [THR_W-1:0] steady_lvl = STEADY_LEVEL_RST;
  logic [LIM_W-1:0] integ_limit = INTEGRAL_LIMIT_RST;
  logic signed [ENERGY_W-1:0] tgt_energy = '0;
  logic signed [ENERGY_W-1:0] meas_energy = '0;
  longint integ_acc = 0;
  bit tgt_seen = 1'b0;
  bit meas_seen = 1'b0;

  ctrl_item_t pending[$];
  logic [THR_W-1:0] throttle_expected[$];
  ctrl_item_t cur_item;
  bit calm = 1'b0;
  int n_errors = 0;
  int n_results = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic void predict_throttle(input ctrl_item_t it);
    longint err, sum, lim, corr, level;
    case (it.opcode)
      OP_SET_TARGET: begin
        tgt_energy = it.energy;
        tgt_seen = 1'b1;
      end
      OP_SET_MEASURED: begin
        meas_energy = it.energy;
        meas_seen = 1'b1;
      end
      OP_TICK: begin
        if (tgt_seen && meas_seen && it.dt != '0 && it.dt <= DT_ONE) begin
          err = longint'(tgt_energy) - longint'(meas_energy);
          sum = integ_acc + ((err * longint'(it.dt)) >>> FRAC_W);
          lim = longint'(integ_limit);
          if (sum > lim) sum = lim;
          if (sum < -lim) sum = -lim;
          integ_acc = sum;
          corr = (longint'(gain_p) * err + longint'(gain_i) * integ_acc) >>> FRAC_W;
          level = longint'(steady_lvl) + corr;
          if (level > longint'(ceiling_lvl)) level = longint'(ceiling_lvl);
          if (level < longint'(floor_lvl)) level = longint'(floor_lvl);
          throttle_expected.push_back(level[THR_W-1:0]);
        end
      end
      default: ;
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_throttle(cur_item);
      if (!in_valid || !in_stall) begin
        if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_item = pending.pop_front();
          in_valid <= 1'b1;
          in_opcode <= cur_item.opcode;
          in_energy_value <= cur_item.energy;
          in_elapsed_time <= cur_item.dt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    logic [THR_W-1:0] exp_thr;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (throttle_expected.size() == 0) begin
          $error("unexpected throttle item: actual %0d", out_throttle);
          n_errors++;
        end else begin
          exp_thr = throttle_expected.pop_front();
          if (out_throttle !== exp_thr) begin
            $error("throttle mismatch: expected %0d, actual %0d", exp_thr, out_throttle);
            n_errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && n_results >= 25) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  function automatic ctrl_item_t mk_item(input logic [1:0] op, input logic [31:0] e,
                                         input logic [DT_W-1:0] dt);
    ctrl_item_t it;
    it.opcode = op;
    it.energy = e;
    it.dt = dt;
    return it;
  endfunction

  // queue an item, tell whether it does anything in the block
  function automatic int queue_item(input ctrl_item_t it);
    pending.push_back(it);
    if (it.opcode == OP_UNUSED) return 0;
    if (it.opcode == OP_TICK && (it.dt == '0 || it.dt > DT_ONE)) return 0;
    return 1;
  endfunction

  function automatic logic [ENERGY_W-1:0] rand_energy();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 262144) - 131072;
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(0, 7))
      0: return DT_ONE;
      1: return 17'd1;
      default: return DT_W'($urandom_range(1, 65536));
    endcase
  endfunction

  task automatic queue_random(input int count);
    int made;
    int pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        made += queue_item(mk_item(2'($urandom_range(0, 3)), $urandom,
                                   DT_W'($urandom_range(0, 131071))));
      end else begin
        if (pick < 60) made += queue_item(mk_item(OP_SET_TARGET, rand_energy(), DT_W'($urandom)));
        if (pick >= 40) begin
          made += queue_item(mk_item(OP_SET_MEASURED, rand_energy(), DT_W'($urandom)));
        end
        repeat ($urandom_range(1, 4)) made += queue_item(mk_item(OP_TICK, $urandom, rand_dt()));
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending.size() != 0 || in_valid || throttle_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high so writes can go back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PROP_GAIN: gain_p = data[GAIN_W-1:0];
      REG_INTEG_GAIN: gain_i = data[GAIN_W-1:0];
      REG_THROTTLE_CEILING: ceiling_lvl = data[THR_W-1:0];
      REG_THROTTLE_FLOOR: floor_lvl = data[THR_W-1:0];
      REG_STEADY_LEVEL: steady_lvl = data[THR_W-1:0];
      REG_INTEGRAL_LIMIT: integ_limit = data[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] kp, ki, ceiling_v, floor_v, steady_v, lim_v);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_THROTTLE_CEILING, ceiling_v);
    write_reg(REG_THROTTLE_FLOOR, floor_v);
    write_reg(REG_STEADY_LEVEL, steady_v);
    write_reg(REG_INTEGRAL_LIMIT, lim_v);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings
    pending.push_back(mk_item(OP_TICK, 32'h0, DT_ONE));
    pending.push_back(mk_item(OP_UNUSED, $urandom, DT_ONE));
    pending.push_back(mk_item(OP_SET_TARGET, 32'h7FFF_FFFF, '0));
    pending.push_back(mk_item(OP_TICK, 32'h0, DT_ONE));
    pending.push_back(mk_item(OP_SET_MEASURED, 32'h8000_0000, 17'h1FFFF));
    pending.push_back(mk_item(OP_TICK, 32'hFFFF_FFFF, '0));
    pending.push_back(mk_item(OP_TICK, 32'h0, DT_ONE + 17'd1));
    pending.push_back(mk_item(OP_TICK, 32'h0, 17'h1FFFF));
    pending.push_back(mk_item(OP_TICK, 32'h0, 17'd1));
    pending.push_back(mk_item(OP_TICK, 32'h0, DT_ONE));
    pending.push_back(mk_item(OP_UNUSED, 32'h0001_0000, 17'd1));
    pending.push_back(mk_item(OP_SET_TARGET, 32'h8000_0000, '0));
    pending.push_back(mk_item(OP_SET_MEASURED, 32'h7FFF_FFFF, '0));
    pending.push_back(mk_item(OP_TICK, 32'h0, DT_ONE));
    pending.push_back(mk_item(OP_TICK, 32'h0, 17'd1));
    pending.push_back(mk_item(OP_SET_TARGET, 32'h0, '0));
    pending.push_back(mk_item(OP_SET_MEASURED, 32'h0, '0));
    pending.push_back(mk_item(OP_TICK, 32'h0, 17'd32768));
    pending.push_back(mk_item(OP_SET_TARGET, 32'h0001_0000, '0));
    pending.push_back(mk_item(OP_TICK, 32'h0, 17'd16384));
    pending.push_back(mk_item(OP_TICK, 32'h0, DT_ONE));
    pending.push_back(mk_item(OP_SET_MEASURED, 32'hFFFF_0000, '0));
    pending.push_back(mk_item(OP_TICK, 32'h0, DT_ONE));
    wait_idle();

    // largest gains and limit
    set_regs(32'hFF_FFFF, 32'hFF_FFFF, 32'd65536, 32'd0, 32'd65536, 32'h7FFF_FFFF);
    queue_random(50);
    wait_idle();

    // everything zero
    set_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_random(50);
    wait_idle();

    // no idling on either side
    calm = 1'b1;
    set_regs(32'(PROP_GAIN_RST), 32'(INTEG_GAIN_RST), 32'(THROTTLE_CEILING_RST),
             32'(THROTTLE_FLOOR_RST), 32'(STEADY_LEVEL_RST), 32'(INTEGRAL_LIMIT_RST));
    queue_random(60);
    wait_idle();
    calm = 1'b0;

    // unmapped indexes, wide data, floor above ceiling
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    set_regs($urandom, $urandom, 32'd10000, 32'd50000, $urandom, $urandom);
    queue_random(50);
    wait_idle();

    // ceiling and steady level above full scale
    set_regs(32'd65536, 32'd16384, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'h0004_0000);
    queue_random(40);
    wait_idle();

    repeat (3) begin
      set_regs($urandom_range(0, 131072), $urandom_range(0, 131072),
               $urandom_range(0, 65536), $urandom_range(0, 65536),
               $urandom_range(0, 65536), $urandom_range(0, 1 << 20));
      queue_random(40);
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
